[rtl/clcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clcd_pkg
// Types, constants and microcode store for the 4-bit character LCD sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

  // Request kinds (s_axis_tuser)
  typedef enum logic [2:0] {
    K_INIT   = 3'd0,
    K_CMD    = 3'd1,
    K_CHAR   = 3'd2,
    K_CLEAR  = 3'd3,
    K_CURSOR = 3'd4
  } kind_t;

  // Register indexes on the APB port (byte address = 4 * index)
  typedef enum logic [2:0] {
    R_FUNC_SET  = 3'd0,
    R_DISP_CTRL = 3'd1,
    R_ENTRY     = 3'd2,
    R_PULSE_HI  = 3'd3,
    R_PULSE_LO  = 3'd4
  } reg_idx_t;

  localparam logic [7:0] FUNC_SET_RST  = 8'h28;
  localparam logic [7:0] DISP_CTRL_RST = 8'h0C;
  localparam logic [7:0] ENTRY_RST     = 8'h06;
  localparam logic [5:0] PULSE_HI_RST  = 6'd3;
  localparam logic [7:0] PULSE_LO_RST  = 8'd50;

  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] LINE0_BASE = 8'h80;
  localparam logic [7:0] LINE1_BASE = 8'hC0;
  localparam logic [3:0] INIT_NIB_A = 4'h3;
  localparam logic [3:0] INIT_NIB_B = 4'h2;

  localparam int ROM_DEPTH = 38;
  localparam int PC_W      = $clog2(ROM_DEPTH);
  typedef logic [PC_W-1:0] pc_t;

  // Microcode entry points
  localparam pc_t PC_INIT   = PC_W'(0);
  localparam pc_t PC_BYTE   = PC_W'(25);
  localparam pc_t PC_CLEAR  = PC_W'(29);
  localparam pc_t PC_CURSOR = PC_W'(33);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN} state_t;

  typedef enum logic [2:0] {
    NS_PIN, NS_C3, NS_C2, NS_HI, NS_LO
  } nib_sel_t;

  typedef enum logic [2:0] {
    BS_FSET, BS_DCTL, BS_EMODE, BS_CLEAR, BS_ARG
  } byte_sel_t;

  typedef enum logic [1:0] {
    HS_PH, HS_PL, HS_FIXED
  } hold_sel_t;

  typedef enum logic [1:0] {
    W_NONE, W_GOTO, W_TEN, W_PWR
  } wait_t;

  typedef struct packed {
    logic      en;
    nib_sel_t  nib;
    byte_sel_t byt;
    hold_sel_t hold;
    wait_t     wt;
    logic      last;
  } cw_t;

  function automatic logic [7:0] wait_ms(wait_t w);
    case (w)
      W_NONE:  wait_ms = 8'd0;
      W_GOTO:  wait_ms = 8'd1;
      W_TEN:   wait_ms = 8'd10;
      W_PWR:   wait_ms = 8'd20;
      default: wait_ms = 8'd0;
    endcase
  endfunction

  function automatic cw_t mk(logic en, nib_sel_t n, byte_sel_t b, hold_sel_t h,
                             wait_t w, logic l);
    cw_t c;
    c.en   = en;
    c.nib  = n;
    c.byt  = b;
    c.hold = h;
    c.wt   = w;
    c.last = l;
    return c;
  endfunction

  // Microcode: one pin event per word, run ends at the word with last set.
  function automatic cw_t rom_word(pc_t pc);
    case (pc)
      // init: power-up wait, nibbles 3,3,3,2, then four command bytes
      PC_W'(0):  rom_word = mk(1'b0, NS_PIN, BS_ARG,   HS_FIXED, W_PWR,  1'b0);
      PC_W'(1):  rom_word = mk(1'b1, NS_C3,  BS_ARG,   HS_PH,    W_NONE, 1'b0);
      PC_W'(2):  rom_word = mk(1'b0, NS_C3,  BS_ARG,   HS_PL,    W_TEN,  1'b0);
      PC_W'(3):  rom_word = mk(1'b1, NS_C3,  BS_ARG,   HS_PH,    W_NONE, 1'b0);
      PC_W'(4):  rom_word = mk(1'b0, NS_C3,  BS_ARG,   HS_PL,    W_TEN,  1'b0);
      PC_W'(5):  rom_word = mk(1'b1, NS_C3,  BS_ARG,   HS_PH,    W_NONE, 1'b0);
      PC_W'(6):  rom_word = mk(1'b0, NS_C3,  BS_ARG,   HS_PL,    W_TEN,  1'b0);
      PC_W'(7):  rom_word = mk(1'b1, NS_C2,  BS_ARG,   HS_PH,    W_NONE, 1'b0);
      PC_W'(8):  rom_word = mk(1'b0, NS_C2,  BS_ARG,   HS_PL,    W_TEN,  1'b0);
      PC_W'(9):  rom_word = mk(1'b1, NS_HI,  BS_FSET,  HS_PH,    W_NONE, 1'b0);
      PC_W'(10): rom_word = mk(1'b0, NS_HI,  BS_FSET,  HS_PL,    W_NONE, 1'b0);
      PC_W'(11): rom_word = mk(1'b1, NS_LO,  BS_FSET,  HS_PH,    W_NONE, 1'b0);
      PC_W'(12): rom_word = mk(1'b0, NS_LO,  BS_FSET,  HS_PL,    W_NONE, 1'b0);
      PC_W'(13): rom_word = mk(1'b1, NS_HI,  BS_DCTL,  HS_PH,    W_NONE, 1'b0);
      PC_W'(14): rom_word = mk(1'b0, NS_HI,  BS_DCTL,  HS_PL,    W_NONE, 1'b0);
      PC_W'(15): rom_word = mk(1'b1, NS_LO,  BS_DCTL,  HS_PH,    W_NONE, 1'b0);
      PC_W'(16): rom_word = mk(1'b0, NS_LO,  BS_DCTL,  HS_PL,    W_NONE, 1'b0);
      PC_W'(17): rom_word = mk(1'b1, NS_HI,  BS_EMODE, HS_PH,    W_NONE, 1'b0);
      PC_W'(18): rom_word = mk(1'b0, NS_HI,  BS_EMODE, HS_PL,    W_NONE, 1'b0);
      PC_W'(19): rom_word = mk(1'b1, NS_LO,  BS_EMODE, HS_PH,    W_NONE, 1'b0);
      PC_W'(20): rom_word = mk(1'b0, NS_LO,  BS_EMODE, HS_PL,    W_NONE, 1'b0);
      PC_W'(21): rom_word = mk(1'b1, NS_HI,  BS_CLEAR, HS_PH,    W_NONE, 1'b0);
      PC_W'(22): rom_word = mk(1'b0, NS_HI,  BS_CLEAR, HS_PL,    W_NONE, 1'b0);
      PC_W'(23): rom_word = mk(1'b1, NS_LO,  BS_CLEAR, HS_PH,    W_NONE, 1'b0);
      PC_W'(24): rom_word = mk(1'b0, NS_LO,  BS_CLEAR, HS_PL,    W_NONE, 1'b1);
      // command / character byte
      PC_W'(25): rom_word = mk(1'b1, NS_HI,  BS_ARG,   HS_PH,    W_NONE, 1'b0);
      PC_W'(26): rom_word = mk(1'b0, NS_HI,  BS_ARG,   HS_PL,    W_NONE, 1'b0);
      PC_W'(27): rom_word = mk(1'b1, NS_LO,  BS_ARG,   HS_PH,    W_NONE, 1'b0);
      PC_W'(28): rom_word = mk(1'b0, NS_LO,  BS_ARG,   HS_PL,    W_NONE, 1'b1);
      // clear display
      PC_W'(29): rom_word = mk(1'b1, NS_HI,  BS_CLEAR, HS_PH,    W_NONE, 1'b0);
      PC_W'(30): rom_word = mk(1'b0, NS_HI,  BS_CLEAR, HS_PL,    W_NONE, 1'b0);
      PC_W'(31): rom_word = mk(1'b1, NS_LO,  BS_CLEAR, HS_PH,    W_NONE, 1'b0);
      PC_W'(32): rom_word = mk(1'b0, NS_LO,  BS_CLEAR, HS_PL,    W_TEN,  1'b1);
      // cursor move
      PC_W'(33): rom_word = mk(1'b0, NS_PIN, BS_ARG,   HS_FIXED, W_GOTO, 1'b0);
      PC_W'(34): rom_word = mk(1'b1, NS_HI,  BS_ARG,   HS_PH,    W_NONE, 1'b0);
      PC_W'(35): rom_word = mk(1'b0, NS_HI,  BS_ARG,   HS_PL,    W_NONE, 1'b0);
      PC_W'(36): rom_word = mk(1'b1, NS_LO,  BS_ARG,   HS_PH,    W_NONE, 1'b0);
      PC_W'(37): rom_word = mk(1'b0, NS_LO,  BS_ARG,   HS_PL,    W_GOTO, 1'b1);
      default:   rom_word = mk(1'b0, NS_PIN, BS_ARG,   HS_FIXED, W_NONE, 1'b1);
    endcase
  endfunction

  function automatic pc_t entry_pc(logic [2:0] kind);
    case (kind)
      K_INIT:   entry_pc = PC_INIT;
      K_CMD:    entry_pc = PC_BYTE;
      K_CHAR:   entry_pc = PC_BYTE;
      K_CLEAR:  entry_pc = PC_CLEAR;
      K_CURSOR: entry_pc = PC_CURSOR;
      default:  entry_pc = PC_INIT;
    endcase
  endfunction

endpackage

[rtl/char_lcd_four_bit_sequencer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_four_bit_sequencer_core
// Turns LCD requests (init, command, character, clear, cursor move) into runs
// of pin events for a 4-bit HD44780-style bus, driven by a microcode store.
// ----------------------------------------------------------------------------
//
//  channel   | dir | transfer carries
//  ----------+-----+---------------------------------------------------------
//  s_axis    | in  | one request: kind, data_byte, row, col
//  m_axis    | out | one pin event: rs, en, nibble, hold_ms; tlast ends a run
//  apb       | in  | register writes / reads (5 x 32-bit, byte address 4*i)
//
//  One pin event per cycle: a step of the microcode counter fills the output
//  register whenever it is empty or being drained. An accepted request runs
//  one event per microcode word: 4 for command, character and clear, 5 for
//  cursor move, 25 for init. s_axis_tready is low for the whole run.
//  Output stalls freeze the step counter. Unknown kinds are accepted and
//  dropped. Synchronous reset restores register defaults and data lines to 0.
//
module char_lcd_four_bit_sequencer_core
  import clcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [8] row, [14:9] col, [15] 0
  input  logic [2:0]  s_axis_tuser,   // [2:0] kind

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] en, [4:1] nibble, [12:5] hold_ms, [15:13] 0
  output logic        m_axis_tuser,   // [0] rs
  output logic        m_axis_tlast,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [7:0] func_set;
  logic [7:0] disp_ctrl;
  logic [7:0] entry_mode;
  logic [5:0] pulse_hi;
  logic [7:0] pulse_lo;

  // sequencer
  state_t     state, state_next;
  pc_t        pc;
  logic [7:0] arg_byte;     // data byte or cursor address for this run
  logic       rs_char;      // run is a character write
  logic [3:0] pin_nibble;   // data-line levels last driven

  logic       in_fire;
  logic       kind_ok;
  logic       step_fire;
  cw_t        cw;
  logic [7:0] cur_byte;
  logic [3:0] ev_nib;
  logic [7:0] ev_hold;
  logic [8:0] lo_sum;
  logic [7:0] cursor_addr;

  // output register
  logic       ev_en;
  logic [3:0] ev_nib_q;
  logic [7:0] ev_hold_q;
  logic       ev_rs;
  logic       ev_last;
  logic       out_valid;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  // ---------------------------------------------------------------- APB
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      func_set   <= FUNC_SET_RST;
      disp_ctrl  <= DISP_CTRL_RST;
      entry_mode <= ENTRY_RST;
      pulse_hi   <= PULSE_HI_RST;
      pulse_lo   <= PULSE_LO_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        R_FUNC_SET:  func_set   <= pwdata[7:0];
        R_DISP_CTRL: disp_ctrl  <= pwdata[7:0];
        R_ENTRY:     entry_mode <= pwdata[7:0];
        R_PULSE_HI:  pulse_hi   <= pwdata[5:0];
        R_PULSE_LO:  pulse_lo   <= pwdata[7:0];
        default: ;  // unmapped: write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      R_FUNC_SET:  prdata = {24'd0, func_set};
      R_DISP_CTRL: prdata = {24'd0, disp_ctrl};
      R_ENTRY:     prdata = {24'd0, entry_mode};
      R_PULSE_HI:  prdata = {26'd0, pulse_hi};
      R_PULSE_LO:  prdata = {24'd0, pulse_lo};
      default:     prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- control
  assign kind_ok = s_axis_tuser inside {K_INIT, K_CMD, K_CHAR, K_CLEAR, K_CURSOR};
  assign in_fire = s_axis_tvalid & s_axis_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_fire && kind_ok) state_next = ST_RUN;
      ST_RUN:  if (step_fire && cw.last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    step_fire     = (state == ST_RUN) && (!out_valid || m_axis_tready);
  end

  // line base plus column, wraps at 8 bits
  assign cursor_addr = (s_axis_tdata[8] ? LINE1_BASE : LINE0_BASE)
                       + {2'b00, s_axis_tdata[14:9]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pc         <= PC_INIT;
      pin_nibble <= 4'd0;
    end else begin
      state <= state_next;
      if (in_fire && kind_ok) begin
        pc <= entry_pc(s_axis_tuser);
      end else if (step_fire) begin
        pc <= pc + PC_W'(1);
      end
      if (step_fire) begin
        pin_nibble <= ev_nib;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      arg_byte <= (s_axis_tuser == K_CURSOR) ? cursor_addr : s_axis_tdata[7:0];
      rs_char  <= (s_axis_tuser == K_CHAR);
    end
  end

  // ---------------------------------------------------------------- datapath
  assign cw = rom_word(pc);

  always_comb begin
    case (cw.byt)
      BS_FSET:  cur_byte = func_set;
      BS_DCTL:  cur_byte = disp_ctrl;
      BS_EMODE: cur_byte = entry_mode;
      BS_CLEAR: cur_byte = CMD_CLEAR;
      BS_ARG:   cur_byte = arg_byte;
      default:  cur_byte = arg_byte;
    endcase
  end

  always_comb begin
    case (cw.nib)
      NS_PIN:  ev_nib = pin_nibble;
      NS_C3:   ev_nib = INIT_NIB_A;
      NS_C2:   ev_nib = INIT_NIB_B;
      NS_HI:   ev_nib = cur_byte[7:4];
      NS_LO:   ev_nib = cur_byte[3:0];
      default: ev_nib = pin_nibble;
    endcase
  end

  // EN-low hold plus any trailing wait, saturating at 255 ms
  assign lo_sum = {1'b0, pulse_lo} + {1'b0, wait_ms(cw.wt)};

  always_comb begin
    case (cw.hold)
      HS_PH:    ev_hold = {2'b00, pulse_hi};
      HS_PL:    ev_hold = lo_sum[8] ? 8'hFF : lo_sum[7:0];
      HS_FIXED: ev_hold = wait_ms(cw.wt);
      default:  ev_hold = wait_ms(cw.wt);
    endcase
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      ev_en     <= cw.en;
      ev_nib_q  <= ev_nib;
      ev_hold_q <= ev_hold;
      ev_rs     <= rs_char;
      ev_last   <= cw.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, ev_hold_q, ev_nib_q, ev_en};
  assign m_axis_tuser  = ev_rs;
  assign m_axis_tlast  = ev_last;

`ifndef SYNTHESIS
  a_no_accept_in_run: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> !s_axis_tready)
    else $error("request accepted during a run");

  a_run_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    step_fire && cw.last |=> state == ST_IDLE && m_axis_tlast && m_axis_tvalid)
    else $error("run did not end on its final event");

  a_pc_in_rom: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> pc < PC_W'(ROM_DEPTH))
    else $error("step counter left the microcode store");
`endif

endmodule
